[hdl/kvdc_pkg.sv]
package kvdc_pkg;

    // Defaults for the top-level parameters
    localparam int ALPHABET_DEF  = 256;
    localparam int MAX_FRAME_DEF = 4096;
    localparam int MULT_BITS_DEF = 8;

    // Fixed field widths
    localparam int SYM_W      = 8;
    localparam int LEN_W      = 13;
    localparam int GENUS_W    = 7;
    localparam int MODE_W     = 2;
    localparam int COST_OUT_W = 35;
    localparam int COST_W     = 36;
    localparam int SCORE_W    = 20;
    localparam int ROW_W      = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Sequential arithmetic unit
    localparam int DIV_STEPS = SCORE_W;
    localparam int MUL_B_W   = 22;
    localparam int MUL_STEPS = MUL_B_W;
    localparam int PROD_W    = COST_W + MUL_B_W;
    localparam int STEP_W    = $clog2(MUL_STEPS + 1);

    typedef enum logic [MODE_W-1:0] {
        MODE_KV  = 2'd0,
        MODE_HKV = 2'd1,
        MODE_GS  = 2'd2,
        MODE_HGS = 2'd3
    } mode_t;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE        = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CODE_LENGTH = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INFO_LENGTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_GENUS       = 2'd3;

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_PAIR = 1'b1;

    typedef struct packed {
        logic             kind;
        logic [SYM_W-1:0] x_symbol;
        logic [SYM_W-1:0] y_symbol;
        logic [SYM_W-1:0] mult_value;
    } in_item_t;

    typedef struct packed {
        logic                  success;
        logic [COST_OUT_W-1:0] total_cost;
        logic [SCORE_W-1:0]    total_score;
        logic [LEN_W-1:0]      mismatch_count;
    } out_item_t;

    typedef enum logic [3:0] {
        OP_NONE       = 4'd0,
        OP_CLEAR      = 4'd1,
        OP_CAPTURE    = 4'd2,
        OP_READ       = 4'd3,
        OP_EXEC       = 4'd4,
        OP_DIV_START  = 4'd5,
        OP_DIV_STEP   = 4'd6,
        OP_MULA_START = 4'd7,
        OP_MULB_START = 4'd8,
        OP_MUL_STEP   = 4'd9,
        OP_RESULT     = 4'd10
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic  clear_last;
        logic  frame_end;
        logic  div_last;
        logic  mul_last;
        logic  out_free;
        mode_t mode;
    } dp_status_t;

endpackage

[hdl/kvdc_ctrl.sv]
module kvdc_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  kvdc_pkg::dp_status_t status,
    output kvdc_pkg::dp_cmd_t    cmd
);
    import kvdc_pkg::*;

    typedef enum logic [10:0] {
        ST_CLEAR = 11'b000_0000_0001,
        ST_IDLE  = 11'b000_0000_0010,
        ST_RD    = 11'b000_0000_0100,
        ST_EXEC  = 11'b000_0000_1000,
        ST_PREP  = 11'b000_0001_0000,
        ST_DIV   = 11'b000_0010_0000,
        ST_MSETA = 11'b000_0100_0000,
        ST_MULA  = 11'b000_1000_0000,
        ST_MSETB = 11'b001_0000_0000,
        ST_MULB  = 11'b010_0000_0000,
        ST_CMP   = 11'b100_0000_0000
    } ctrl_state_t;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        in_stall   = 1'b1;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.op = OP_CLEAR;
                if (status.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.op     = OP_CAPTURE;
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                cmd.op     = OP_READ;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                cmd.op     = OP_EXEC;
                state_next = status.frame_end ? ST_PREP : ST_IDLE;
            end
            ST_PREP:
            begin
                if (status.mode == MODE_KV)
                begin
                    cmd.op     = OP_DIV_START;
                    state_next = ST_DIV;
                end
                else
                begin
                    cmd.op     = OP_MULA_START;
                    state_next = ST_MULA;
                end
            end
            ST_DIV:
            begin
                cmd.op = OP_DIV_STEP;
                if (status.div_last)
                begin
                    state_next = ST_MSETA;
                end
            end
            ST_MSETA:
            begin
                cmd.op     = OP_MULA_START;
                state_next = ST_MULA;
            end
            ST_MULA:
            begin
                cmd.op = OP_MUL_STEP;
                if (status.mul_last)
                begin
                    state_next = ST_MSETB;
                end
            end
            ST_MSETB:
            begin
                cmd.op     = OP_MULB_START;
                state_next = ST_MULB;
            end
            ST_MULB:
            begin
                cmd.op = OP_MUL_STEP;
                if (status.mul_last)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (status.out_free)
                begin
                    cmd.op     = OP_RESULT;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[hdl/kvdc_datapath.sv]
module kvdc_datapath #(
    parameter int ALPHABET  = kvdc_pkg::ALPHABET_DEF,
    parameter int MAX_FRAME = kvdc_pkg::MAX_FRAME_DEF,
    parameter int MULT_BITS = kvdc_pkg::MULT_BITS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  kvdc_pkg::in_item_t                   in_item,
    input  logic                                 cfg_valid,
    input  logic [kvdc_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [kvdc_pkg::CFG_DATA_W-1:0]      cfg_data,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output kvdc_pkg::out_item_t                  out_item,
    input  kvdc_pkg::dp_cmd_t                    cmd,
    output kvdc_pkg::dp_status_t                 status
);
    import kvdc_pkg::*;

    localparam int SYM_BITS  = (ALPHABET > 2) ? $clog2(ALPHABET) : 1;
    localparam int TBL_AW    = 2 * SYM_BITS;
    localparam int TBL_DEPTH = 1 << TBL_AW;
    localparam int ROW_DEPTH = 1 << SYM_BITS;
    localparam int TRI_W     = 2 * MULT_BITS + 1;

    function automatic logic [ROW_W-1:0] tri_num(input logic [MULT_BITS-1:0] m);
        logic [TRI_W-1:0] p;
        p = TRI_W'(m) * (TRI_W'(m) + TRI_W'(1));
        return ROW_W'(p >> 1);
    endfunction

    // Configuration
    mode_t              mode_reg;
    logic [LEN_W-1:0]   code_len_reg;
    logic [LEN_W-1:0]   info_len_reg;
    logic [GENUS_W-1:0] genus_reg;

    // Storage
    logic [MULT_BITS-1:0] tbl_mem [TBL_DEPTH];
    logic [ROW_W-1:0]     row_mem [ROW_DEPTH];
    logic [MULT_BITS-1:0] tbl_rd_reg;
    logic [ROW_W-1:0]     row_rd_reg;
    logic [TBL_AW-1:0]    clr_addr_reg;

    // Frame state
    in_item_t           item_reg;
    logic [COST_W-1:0]  cost_reg;
    logic [SCORE_W-1:0] score_reg;
    logic [LEN_W-1:0]   mismatch_reg;
    logic [LEN_W-1:0]   pos_reg;

    // Snapshot of a finished frame
    logic [COST_W-1:0]  c_snap_reg;
    logic [SCORE_W-1:0] s_snap_reg;
    logic [LEN_W-1:0]   e_snap_reg;
    logic [LEN_W-1:0]   n_snap_reg;

    // Arithmetic unit
    logic [SCORE_W-1:0] div_q_reg;
    logic [LEN_W-1:0]   div_rem_reg;
    logic [PROD_W-1:0]  mul_a_reg;
    logic [MUL_B_W-1:0] mul_b_reg;
    logic [PROD_W-1:0]  prod_reg;
    logic [PROD_W-1:0]  rhs_reg;
    logic [STEP_W-1:0]  step_reg;

    out_item_t out_item_reg;
    logic      out_valid_reg;

    // Derived values
    logic [LEN_W-1:0]   km1;
    logic [LEN_W-1:0]   kk;
    logic [LEN_W:0]     kg;
    logic [LEN_W:0]     ksum;
    logic [LEN_W:0]     f_gs;
    logic [LEN_W-1:0]   n_clamp;
    logic [LEN_W-1:0]   n_lim;
    logic               x_in;
    logic               y_in;
    logic               in_range;
    logic [TBL_AW-1:0]  tbl_addr;
    logic [SYM_BITS-1:0] row_addr;
    logic [LEN_W-1:0]   pos_inc;
    logic               frame_end;
    logic [COST_W:0]    cost_sum;
    logic [COST_W-1:0]  cost_new;
    logic [SCORE_W:0]   score_sum;
    logic [SCORE_W-1:0] score_new;
    logic [LEN_W-1:0]   mismatch_new;
    logic [MULT_BITS-1:0] load_val;
    logic [LEN_W:0]     div_shift;
    logic               div_fit;
    logic [SCORE_W-1:0] t_val;
    logic [LEN_W-1:0]   r_val;
    logic [MUL_B_W-1:0] f2_val;
    logic               ok;
    logic               lhs_gt;
    logic               success;

    assign km1   = (info_len_reg != '0) ? info_len_reg - LEN_W'(1) : '0;
    assign kk    = (km1 != '0) ? km1 : LEN_W'(1);
    assign kg    = {1'b0, km1} + (LEN_W+1)'(genus_reg);
    assign ksum  = {1'b0, info_len_reg} + (LEN_W+1)'(genus_reg);
    assign f_gs  = (mode_reg == MODE_HGS)
                 ? ((ksum != '0) ? ksum - (LEN_W+1)'(1) : '0)
                 : {1'b0, info_len_reg};
    assign n_lim   = LEN_W'(MAX_FRAME);
    assign n_clamp = (code_len_reg == '0) ? LEN_W'(1)
                   : (code_len_reg > n_lim) ? n_lim : code_len_reg;

    assign x_in     = {1'b0, item_reg.x_symbol} < (SYM_W+1)'(ALPHABET);
    assign y_in     = {1'b0, item_reg.y_symbol} < (SYM_W+1)'(ALPHABET);
    assign in_range = x_in && y_in;
    assign row_addr = item_reg.x_symbol[SYM_BITS-1:0];
    assign tbl_addr = {item_reg.x_symbol[SYM_BITS-1:0], item_reg.y_symbol[SYM_BITS-1:0]};
    assign load_val = MULT_BITS'(item_reg.mult_value);

    assign pos_inc   = pos_reg + LEN_W'(1);
    assign frame_end = (item_reg.kind == KIND_PAIR) && (pos_inc >= n_clamp);

    // Saturating cost and score accumulation; out-of-alphabet pairs add nothing to them
    assign cost_sum  = {1'b0, cost_reg} + (COST_W+1)'(row_rd_reg);
    assign score_sum = {1'b0, score_reg} + (SCORE_W+1)'(tbl_rd_reg);
    assign cost_new  = !in_range ? cost_reg
                     : cost_sum[COST_W] ? '1 : cost_sum[COST_W-1:0];
    assign score_new = !in_range ? score_reg
                     : score_sum[SCORE_W] ? '1 : score_sum[SCORE_W-1:0];
    assign mismatch_new = (item_reg.x_symbol != item_reg.y_symbol)
                        ? mismatch_reg + LEN_W'(1) : mismatch_reg;

    // Restoring divide step
    assign div_shift = {div_rem_reg, div_q_reg[SCORE_W-1]};
    assign div_fit   = div_shift >= {1'b0, kk};

    // Second-stage operands
    assign t_val  = s_snap_reg - SCORE_W'(genus_reg);
    assign r_val  = n_snap_reg - e_snap_reg;
    assign f2_val = {1'b0, s_snap_reg, 1'b0} - prod_reg[MUL_B_W-1:0];

    always_comb
    begin
        case (mode_reg)
            MODE_KV:
            begin
                ok     = s_snap_reg != '0;
                lhs_gt = prod_reg > PROD_W'({c_snap_reg, 1'b0});
            end
            MODE_HKV:
            begin
                ok     = s_snap_reg > SCORE_W'(genus_reg);
                lhs_gt = {1'b0, prod_reg} > {rhs_reg, 1'b0};
            end
            default:
            begin
                ok     = n_snap_reg > e_snap_reg;
                lhs_gt = prod_reg > rhs_reg;
            end
        endcase
        success = ok && lhs_gt;
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_KV;
            code_len_reg <= LEN_W'(255);
            info_len_reg <= LEN_W'(223);
            genus_reg    <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_MODE:        mode_reg     <= mode_t'(cfg_data[MODE_W-1:0]);
                CFG_CODE_LENGTH: code_len_reg <= cfg_data;
                CFG_INFO_LENGTH: info_len_reg <= cfg_data;
                CFG_GENUS:       genus_reg    <= cfg_data[GENUS_W-1:0];
                default:         mode_reg     <= mode_reg;
            endcase
        end
    end

    // Table and row-sum memories
    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_CLEAR)
        begin
            tbl_mem[clr_addr_reg] <= '0;
            if (clr_addr_reg[TBL_AW-1:SYM_BITS] == '0)
            begin
                row_mem[clr_addr_reg[SYM_BITS-1:0]] <= '0;
            end
        end
        else if (cmd.op == OP_EXEC && item_reg.kind == KIND_LOAD && in_range)
        begin
            tbl_mem[tbl_addr] <= load_val;
            row_mem[row_addr] <= row_rd_reg + tri_num(load_val) - tri_num(tbl_rd_reg);
        end
        if (cmd.op == OP_READ)
        begin
            tbl_rd_reg <= tbl_mem[tbl_addr];
            row_rd_reg <= row_mem[row_addr];
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_CAPTURE:
            begin
                item_reg <= in_item;
            end
            OP_EXEC:
            begin
                c_snap_reg <= cost_new;
                s_snap_reg <= score_new;
                e_snap_reg <= mismatch_new;
                n_snap_reg <= n_clamp;
            end
            OP_DIV_START:
            begin
                div_q_reg   <= s_snap_reg - SCORE_W'(1);
                div_rem_reg <= '0;
            end
            OP_DIV_STEP:
            begin
                div_q_reg   <= {div_q_reg[SCORE_W-2:0], div_fit};
                div_rem_reg <= div_fit ? LEN_W'(div_shift - {1'b0, kk}) : LEN_W'(div_shift);
            end
            OP_MULA_START:
            begin
                prod_reg <= '0;
                case (mode_reg)
                    MODE_KV:
                    begin
                        mul_a_reg <= PROD_W'(div_q_reg);
                        mul_b_reg <= MUL_B_W'(kk);
                    end
                    MODE_HKV:
                    begin
                        mul_a_reg <= PROD_W'(c_snap_reg);
                        mul_b_reg <= MUL_B_W'(kg);
                    end
                    default:
                    begin
                        mul_a_reg <= PROD_W'(n_snap_reg);
                        mul_b_reg <= MUL_B_W'(f_gs);
                    end
                endcase
            end
            OP_MULB_START:
            begin
                rhs_reg  <= prod_reg;
                prod_reg <= '0;
                case (mode_reg)
                    MODE_KV:
                    begin
                        mul_a_reg <= PROD_W'(div_q_reg) + PROD_W'(1);
                        mul_b_reg <= f2_val;
                    end
                    MODE_HKV:
                    begin
                        mul_a_reg <= PROD_W'(t_val);
                        mul_b_reg <= MUL_B_W'(t_val);
                    end
                    default:
                    begin
                        mul_a_reg <= PROD_W'(r_val);
                        mul_b_reg <= MUL_B_W'(r_val);
                    end
                endcase
            end
            OP_MUL_STEP:
            begin
                if (mul_b_reg[0])
                begin
                    prod_reg <= prod_reg + mul_a_reg;
                end
                mul_a_reg <= mul_a_reg << 1;
                mul_b_reg <= mul_b_reg >> 1;
            end
            OP_RESULT:
            begin
                out_item_reg.success        <= success;
                out_item_reg.total_cost     <= c_snap_reg[COST_OUT_W-1:0];
                out_item_reg.total_score    <= s_snap_reg;
                out_item_reg.mismatch_count <= e_snap_reg;
            end
            default:
            begin
                item_reg <= item_reg;
            end
        endcase
    end

    // Control state of the datapath
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            cost_reg      <= '0;
            score_reg     <= '0;
            mismatch_reg  <= '0;
            pos_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_CLEAR)
            begin
                clr_addr_reg <= clr_addr_reg + TBL_AW'(1);
            end
            if (cmd.op == OP_EXEC && item_reg.kind == KIND_PAIR)
            begin
                if (frame_end)
                begin
                    cost_reg     <= '0;
                    score_reg    <= '0;
                    mismatch_reg <= '0;
                    pos_reg      <= '0;
                end
                else
                begin
                    cost_reg     <= cost_new;
                    score_reg    <= score_new;
                    mismatch_reg <= mismatch_new;
                    pos_reg      <= pos_inc;
                end
            end
            if (cmd.op == OP_DIV_START || cmd.op == OP_MULA_START || cmd.op == OP_MULB_START)
            begin
                step_reg <= '0;
            end
            else if (cmd.op == OP_DIV_STEP || cmd.op == OP_MUL_STEP)
            begin
                step_reg <= step_reg + STEP_W'(1);
            end
            if (cmd.op == OP_RESULT)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last = &clr_addr_reg;
    assign status.frame_end  = frame_end;
    assign status.div_last   = step_reg == STEP_W'(DIV_STEPS - 1);
    assign status.mul_last   = step_reg == STEP_W'(MUL_STEPS - 1);
    assign status.out_free   = !out_valid_reg || !out_stall;
    assign status.mode       = mode_reg;

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

    a_result_slot_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_RESULT) |-> (!out_valid_reg || !out_stall))
        else $error("result written over a held beat");

    a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_EXEC && frame_end) |=> (pos_reg == '0 && mismatch_reg == '0))
        else $error("frame accumulators not cleared at frame end");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == OP_MUL_STEP) |-> (step_reg < STEP_W'(MUL_STEPS)))
        else $error("multiplier ran past its last step");

endmodule

[hdl/kv_decodability_check.sv]
// Koetter-Vardy decodability check. Load the multiplicity table with beats of
// kind 0 (row x, column y, value); each load also keeps the row sum of
// m(m+1)/2 current. Beats of kind 1 are the symbol pairs of a frame; after
// code_length pairs (clamped to 1..MAX_FRAME) one result beat carries the
// success flag of the selected criterion with the frame's cost, score and
// mismatch count. After reset the block sweeps the table to zero, one entry
// per cycle, over all ALPHABET-rounded-up-to-a-power-of-two squared entries
// (65536 at the default) and holds in_stall high meanwhile; configuration
// writes are taken during the sweep. Each beat passes capture, memory read and
// update before the next beat is taken. The last pair of a frame adds the
// decision: two 22-step shift-add multiplies, each behind a set-up state, and
// a compare state that waits until the output register is free; in KV mode a
// 20-step restoring divide with its own set-up state comes in front of them.
// A finished result waits in the output register while new beats are taken;
// the next frame's decision holds until that beat is gone. Write configuration
// only while the block is idle.
module kv_decodability_check #(
    parameter int ALPHABET  = kvdc_pkg::ALPHABET_DEF,
    parameter int MAX_FRAME = kvdc_pkg::MAX_FRAME_DEF,
    parameter int MULT_BITS = kvdc_pkg::MULT_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  kvdc_pkg::in_item_t              in_item,
    output logic                            out_valid,
    input  logic                            out_stall,
    output kvdc_pkg::out_item_t             out_item,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [kvdc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [kvdc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import kvdc_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    // Registers accept a write in any cycle
    assign cfg_ready = 1'b1;

    kvdc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    kvdc_datapath #(
        .ALPHABET  (ALPHABET),
        .MAX_FRAME (MAX_FRAME),
        .MULT_BITS (MULT_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_item   (in_item),
        .cfg_valid (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

[dv/tb_kv_decodability_check.sv]
`timescale 1ns / 1ps

module tb_kv_decodability_check;
    import kvdc_pkg::*;

    localparam int     MAX_FRAME_N = MAX_FRAME_DEF;
    localparam longint COST_SAT    = (64'd1 << COST_W) - 1;
    localparam longint SCORE_SAT   = (64'd1 << SCORE_W) - 1;
    localparam int     SETTLE      = 120;      // extra wait at the end of each drain
    localparam int     CYCLE_LIMIT = 1_000_000; // covers the table sweep plus all items

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    in_item_t              in_item;
    logic                  out_valid;
    logic                  out_stall;
    out_item_t             out_item;
    logic                  cfg_valid;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    kv_decodability_check i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_item  (out_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock: 8 ns period
    initial clk = 1'b0;
    always #4 clk = ~clk;

    // ------------------------------------------------------------------
    // Shadow of the block: multiplicity table, row sums, frame accumulators
    // and configuration registers.
    // ------------------------------------------------------------------
    logic [7:0]        mult_mem [0:65535];
    logic [ROW_W-1:0]  row_sum  [0:255];
    longint unsigned   frame_cost;
    longint unsigned   frame_score;
    logic [LEN_W-1:0]  frame_errs;
    logic [LEN_W-1:0]  frame_pos;

    mode_t             sh_mode;
    logic [LEN_W-1:0]  sh_len;
    logic [LEN_W-1:0]  sh_info;
    logic [GENUS_W-1:0] sh_genus;

    out_item_t         frame_results [$];
    int                err_cnt;
    longint            cycle_cnt;

    // Keep (x, y) pairs that were loaded so frames hit loaded entries.
    logic [15:0]       loaded_pairs [$];

    int                burst_left;
    int                stall_style;

    function automatic longint unsigned tri_cost(input longint unsigned m);
        return (m * (m + 1)) / 2;
    endfunction

    // Success flag of the selected criterion, exact integer arithmetic.
    function automatic bit frame_decodes(input longint unsigned c, input longint unsigned s,
                                         input longint unsigned e, input longint unsigned n);
        longint unsigned k, g, km1, kk, d, m, t, f, r;
        k   = sh_info;
        g   = sh_genus;
        km1 = (k > 0) ? k - 1 : 0;
        case (sh_mode)
            MODE_KV:
            begin
                kk = (km1 > 0) ? km1 : 1;
                if (s == 0)
                    return 1'b0;
                d = s - 1;
                m = d / kk;
                return (m + 1) * (2 * (d + 1) - kk * m) > 2 * c;
            end
            MODE_HKV:
            begin
                if (s <= g)
                    return 1'b0;
                t = s - g;
                return t * t > 2 * (km1 + g) * c;
            end
            default:
            begin
                f = k;
                if (sh_mode == MODE_HGS)
                    f = (k + g > 0) ? k + g - 1 : 0;
                if (n <= e)
                    return 1'b0;
                r = n - e;
                return r * r > n * f;
            end
        endcase
    endfunction

    // Advance the shadow by one accepted beat; report a frame result if one ends.
    task automatic predict_beat(input in_item_t it, output bit has_res, output out_item_t res);
        logic [15:0]     slot;
        longint unsigned v, old, sc, n;
        has_res = 1'b0;
        res     = '0;
        slot    = {it.x_symbol, it.y_symbol};
        if (it.kind == KIND_LOAD)
        begin
            v   = it.mult_value;
            old = mult_mem[slot];
            row_sum[it.x_symbol] = ROW_W'(row_sum[it.x_symbol] + tri_cost(v) - tri_cost(old));
            mult_mem[slot] = it.mult_value;
            return;
        end
        frame_cost = frame_cost + row_sum[it.x_symbol];
        if (frame_cost > COST_SAT)
            frame_cost = COST_SAT;
        sc = frame_score + mult_mem[slot];
        frame_score = (sc > SCORE_SAT) ? SCORE_SAT : sc;
        if (it.x_symbol != it.y_symbol)
            frame_errs = LEN_W'(frame_errs + 1);
        frame_pos = LEN_W'(frame_pos + 1);

        n = sh_len;
        if (n < 1)
            n = 1;
        if (n > MAX_FRAME_N)
            n = MAX_FRAME_N;
        if (frame_pos < n)
            return;

        has_res            = 1'b1;
        res.success        = frame_decodes(frame_cost, frame_score, frame_errs, n);
        res.total_cost     = frame_cost[COST_OUT_W-1:0];
        res.total_score    = frame_score[SCORE_W-1:0];
        res.mismatch_count = frame_errs;
        frame_cost  = 0;
        frame_score = 0;
        frame_errs  = '0;
        frame_pos   = '0;
    endtask

    // ------------------------------------------------------------------
    // Result checker: compare each accepted result beat with the oldest
    // predicted frame result.
    // ------------------------------------------------------------------
    task automatic report_miss(input string what, input out_item_t want, input out_item_t got);
        err_cnt++;
        if (err_cnt <= 10)
            $display("[%0t] %s: expected ok=%0d cost=%0d score=%0d errs=%0d,",
                     $realtime, what, want.success, want.total_cost, want.total_score,
                     want.mismatch_count,
                     " got ok=%0d cost=%0d score=%0d errs=%0d",
                     got.success, got.total_cost, got.total_score, got.mismatch_count);
    endtask

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (frame_results.size() == 0)
                report_miss("unexpected result beat", '0, out_item);
            else
            begin
                want = frame_results.pop_front();
                if (want.success !== out_item.success
                    || want.total_cost !== out_item.total_cost
                    || want.total_score !== out_item.total_score
                    || want.mismatch_count !== out_item.mismatch_count)
                    report_miss("result mismatch", want, out_item);
            end
        end
    end

    // Receiver stall: switch between free-flowing, light and heavy stalling.
    always @(negedge clk)
    begin
        if ($urandom_range(0, 199) == 0)
            stall_style = $urandom_range(0, 2);
        case (stall_style)
            0:       out_stall <= 1'b0;
            1:       out_stall <= ($urandom_range(0, 9) < 3);
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt++;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("tb_kv_decodability_check: FAIL");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------

    // Send one beat; idle for a random gap, possibly none, between bursts. Valid stays high inside a burst.
    task automatic send_beat(input in_item_t it, output bit has_res, output out_item_t res);
        int gap;
        if (burst_left == 0)
        begin
            @(negedge clk);
            in_valid = 1'b0;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (gap) @(negedge clk);
            burst_left = $urandom_range(1, 16);
        end
        else
            @(negedge clk);
        burst_left--;
        in_valid = 1'b1;
        in_item  = it;
        do
            @(posedge clk);
        while (in_stall);
        predict_beat(it, has_res, res);
        if (has_res)
            frame_results.insert(frame_results.size(), res);
    endtask

    // Drop valid and wait until every predicted result has come out.
    task automatic drain;
        @(negedge clk);
        in_valid   = 1'b0;
        burst_left = 0;
        while (frame_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            CFG_MODE:        sh_mode  = mode_t'(cfg_data[MODE_W-1:0]);
            CFG_CODE_LENGTH: sh_len   = cfg_data[LEN_W-1:0];
            CFG_INFO_LENGTH: sh_info  = cfg_data[LEN_W-1:0];
            default:         sh_genus = cfg_data[GENUS_W-1:0];
        endcase
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_config(input mode_t md, input int unsigned n, input int unsigned k,
                              input int unsigned g);
        write_reg(CFG_MODE, md);
        write_reg(CFG_CODE_LENGTH, n);
        write_reg(CFG_INFO_LENGTH, k);
        write_reg(CFG_GENUS, g);
    endtask

    // Random beat: loads of random entries, pairs biased to loaded entries and the diagonal.
    function automatic in_item_t random_beat();
        in_item_t    it;
        logic [15:0] slot;
        int          pick;
        it.mult_value = 8'($urandom_range(0, 255));
        it.x_symbol   = 8'($urandom_range(0, 255));
        it.y_symbol   = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 9) < 3)
        begin
            it.kind = KIND_LOAD;
            if ($urandom_range(0, 3) == 0)
                it.y_symbol = it.x_symbol;
            if ($urandom_range(0, 5) == 0)
                it.mult_value = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
            return it;
        end
        it.kind = KIND_PAIR;
        pick = $urandom_range(0, 9);
        if (pick < 6 && loaded_pairs.size() != 0)
        begin
            slot = loaded_pairs[$urandom_range(0, loaded_pairs.size() - 1)];
            it.x_symbol = slot[15:8];
            it.y_symbol = slot[7:0];
        end
        else if (pick < 8)
            it.y_symbol = it.x_symbol;
        return it;
    endfunction

    // ------------------------------------------------------------------
    // Directed table. Mode GS, one pair per frame, k = 0: a pair succeeds
    // exactly when x equals y, so the expected results read off directly.
    // ------------------------------------------------------------------
    typedef struct {
        in_item_t  beat;
        bit        typed;
        out_item_t want;
    } dir_row_t;

    localparam int N_DIR = 12;
    dir_row_t dir_rows [N_DIR] = '{
        // empty table: no cost, no score
        '{'{KIND_PAIR, 8'd0,   8'd0,   8'd0},   1'b1, '{1'b1, 35'd0,     20'd0,   13'd0}},
        '{'{KIND_PAIR, 8'd255, 8'd0,   8'd0},   1'b1, '{1'b0, 35'd0,     20'd0,   13'd1}},
        // load three corners of the table, two with the extreme value 255
        '{'{KIND_LOAD, 8'd0,   8'd0,   8'd255}, 1'b0, '{1'b0, 35'd0,     20'd0,   13'd0}},
        '{'{KIND_LOAD, 8'd0,   8'd255, 8'd1},   1'b0, '{1'b0, 35'd0,     20'd0,   13'd0}},
        '{'{KIND_LOAD, 8'd255, 8'd255, 8'd255}, 1'b0, '{1'b0, 35'd0,     20'd0,   13'd0}},
        '{'{KIND_PAIR, 8'd0,   8'd0,   8'd0},   1'b1, '{1'b1, 35'd32641, 20'd255, 13'd0}},
        '{'{KIND_PAIR, 8'd0,   8'd255, 8'd0},   1'b1, '{1'b0, 35'd32641, 20'd1,   13'd1}},
        '{'{KIND_PAIR, 8'd255, 8'd255, 8'd0},   1'b1, '{1'b1, 35'd32640, 20'd255, 13'd0}},
        // overwrite back to zero: row sum drops again
        '{'{KIND_LOAD, 8'd255, 8'd255, 8'd0},   1'b0, '{1'b0, 35'd0,     20'd0,   13'd0}},
        '{'{KIND_PAIR, 8'd255, 8'd255, 8'd0},   1'b1, '{1'b1, 35'd0,     20'd0,   13'd0}},
        '{'{KIND_LOAD, 8'd170, 8'd85,  8'd170}, 1'b0, '{1'b0, 35'd0,     20'd0,   13'd0}},
        '{'{KIND_PAIR, 8'd170, 8'd85,  8'd85},  1'b0, '{1'b0, 35'd0,     20'd0,   13'd0}}
    };

    // Random phases: mode, code_length, info_length, genus (extremes among them).
    localparam int N_PHASE = 10;
    int unsigned phase_cfg [N_PHASE][4] = '{
        '{MODE_KV,  5,    2,    0},
        '{MODE_KV,  0,    8191, 127},
        '{MODE_HKV, 4,    3,    1},
        '{MODE_HKV, 7,    0,    127},
        '{MODE_GS,  6,    3,    0},
        '{MODE_GS,  8191, 1,    5},  // frame left open, cut short by next phase
        '{MODE_HGS, 5,    0,    0},
        '{MODE_HGS, 3,    4096, 120},
        '{MODE_KV,  12,   1,    60},
        '{MODE_GS,  1,    2,    0}
    };

    initial
    begin
        bit        has_res;
        out_item_t res;
        in_item_t  it;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_item     = '0;
        out_stall   = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = '0;
        cfg_data    = '0;
        err_cnt     = 0;
        cycle_cnt   = 0;
        burst_left  = 0;
        stall_style = 0;
        foreach (mult_mem[i])
            mult_mem[i] = '0;
        foreach (row_sum[i])
            row_sum[i] = '0;
        frame_cost  = 0;
        frame_score = 0;
        frame_errs  = '0;
        frame_pos   = '0;
        sh_mode     = MODE_KV;
        sh_len      = 13'd255;
        sh_info     = 13'd223;
        sh_genus    = '0;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed part
        set_config(MODE_GS, 1, 0, 0);
        foreach (dir_rows[i])
        begin
            send_beat(dir_rows[i].beat, has_res, res);
            if (dir_rows[i].beat.kind == KIND_LOAD)
                loaded_pairs.insert(loaded_pairs.size(),
                                    {dir_rows[i].beat.x_symbol, dir_rows[i].beat.y_symbol});
            if (dir_rows[i].typed && (!has_res || res != dir_rows[i].want))
                report_miss("directed row", dir_rows[i].want, res);
        end
        drain();

        // Random part, 65 beats per setting
        for (int p = 0; p < N_PHASE; p++)
        begin
            set_config(mode_t'(phase_cfg[p][0]), phase_cfg[p][1], phase_cfg[p][2],
                       phase_cfg[p][3]);
            for (int j = 0; j < 65; j++)
            begin
                it = random_beat();
                if (it.kind == KIND_LOAD)
                    loaded_pairs.insert(loaded_pairs.size(), {it.x_symbol, it.y_symbol});
                send_beat(it, has_res, res);
            end
            drain();
        end

        if (err_cnt == 0)
            $display("tb_kv_decodability_check: PASS");
        else
            $display("tb_kv_decodability_check: FAIL");
        $finish;
    end

    // Anything left unmatched at the end counts as a failure via the drain
    // loop above: it never returns and the watchdog ends the run.

endmodule

[filelist.f]
hdl/kvdc_pkg.sv
hdl/kvdc_ctrl.sv
hdl/kvdc_datapath.sv
hdl/kv_decodability_check.sv
dv/tb_kv_decodability_check.sv
